/* src/joint_cube_quantizer_dedup_unit_assert.svh */
// Assertion macros shared by the RTL of the joint cube quantizer.
`ifndef JOINT_CUBE_QUANTIZER_DEDUP_UNIT_ASSERT_SVH
`define JOINT_CUBE_QUANTIZER_DEDUP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on clk, ignored while rst_n is low.
`define JCQD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jcqd assertion failed");
// Checked on clk at every edge, reset included.
`define JCQD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("jcqd assertion failed");
`else
`define JCQD_ASSERT(lbl, prop)
`define JCQD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* src/jcqd_pkg.sv */
`default_nettype none

package jcqd_pkg;

    localparam int NUM_JOINTS_DEF = 20;
    localparam int JOINT_W        = 5;
    localparam int POS_W          = 16;
    localparam int THR_W          = 15;
    localparam int CODE_W         = 5;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ORIGIN_X      = 2'd0,
        CFG_ORIGIN_Y      = 2'd1,
        CFG_ORIGIN_Z      = 2'd2,
        CFG_BIN_THRESHOLD = 2'd3
    } cfg_addr_t;

    typedef struct packed {
        logic        [JOINT_W-1:0] joint_index;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pos_z;
        logic                      gesture_start;
    } in_item_t;

    typedef struct packed {
        logic [JOINT_W-1:0] out_joint;
        logic [CODE_W-1:0]  cube_code;
    } out_item_t;

endpackage

`default_nettype wire

/* src/joint_cube_quantizer_dedup_unit.sv */
`default_nettype none
// Joint cube quantizer with per-joint repeat suppression.
// Input channel (in_valid / in_stall / in_data) takes one joint sample per
// item; output channel (out_valid / out_stall / out_data) gives the joint and
// its new cube code (1..27) whenever the code changed or the joint was not
// seen since the last gesture start. Items with no change give no result.
// Configuration: cfg_we / cfg_addr / cfg_wdata write origin_x, origin_y,
// origin_z and bin_threshold; write only while the block is idle.
// An accepted item is held in the input register and then moves on to the
// result register, which presents its result. Throughput: one item per cycle
// while out_stall holds no result; the per-joint history read-modify-write
// fits in the cycle between the two registers, with the last-code memory read
// registered on accept and a bypass for a write to the same joint in that
// cycle.
// Reset: all seen flags and configuration registers clear, both pipeline
// slots empty. The last-code memory needs no clearing, as an entry is only
// compared while its seen flag is set.
// Stall: while out_stall holds a result, the input register keeps one more
// item; in_stall rises only when that register is full and cannot move on.
module joint_cube_quantizer_dedup_unit
    import jcqd_pkg::*;
#(
    parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data
);

    `include "joint_cube_quantizer_dedup_unit_assert.svh"

    localparam int JIDX_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int EXT_W  = (JIDX_W > JOINT_W) ? JIDX_W : JOINT_W;
    localparam logic [EXT_W:0] JOINT_LIMIT = (EXT_W+1)'(NUM_JOINTS);

    // configuration
    logic signed [POS_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic        [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            thr_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr_t'(cfg_addr))
                CFG_ORIGIN_X:      origin_x_reg <= cfg_wdata;
                CFG_ORIGIN_Y:      origin_y_reg <= cfg_wdata;
                CFG_ORIGIN_Z:      origin_z_reg <= cfg_wdata;
                CFG_BIN_THRESHOLD: thr_reg      <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic      s1_vld_reg;
    in_item_t  s1_reg;
    logic      out_vld_reg;
    out_item_t out_reg;
    logic      s1_go;
    logic      in_acc;

    assign s1_go    = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = s1_vld_reg && !s1_go;
    assign in_acc   = in_valid && !in_stall;

    // joint index decode
    logic [EXT_W-1:0]  in_ext, s1_ext;
    logic [JIDX_W-1:0] in_idx, s1_idx;
    logic              s1_in_range;

    assign in_ext      = EXT_W'(in_data.joint_index);
    assign s1_ext      = EXT_W'(s1_reg.joint_index);
    assign in_idx      = in_ext[JIDX_W-1:0];
    assign s1_idx      = s1_ext[JIDX_W-1:0];
    assign s1_in_range = {1'b0, s1_ext} < JOINT_LIMIT;

    // binning: 0 below -thr, 2 above +thr, 1 otherwise
    logic signed [POS_W+1:0] thr_pos, thr_neg;
    logic signed [POS_W+1:0] dx, dy, dz;
    logic [1:0] bx, by, bz;

    assign thr_pos = $signed({3'b000, thr_reg});
    assign thr_neg = -thr_pos;
    assign dx = (POS_W+2)'(s1_reg.pos_x) - (POS_W+2)'(origin_x_reg);
    assign dy = (POS_W+2)'(s1_reg.pos_y) - (POS_W+2)'(origin_y_reg);
    assign dz = (POS_W+2)'(s1_reg.pos_z) - (POS_W+2)'(origin_z_reg);

    always_comb
    begin
        bx = (dx < thr_neg) ? 2'd0 : ((dx > thr_pos) ? 2'd2 : 2'd1);
        by = (dy < thr_neg) ? 2'd0 : ((dy > thr_pos) ? 2'd2 : 2'd1);
        bz = (dz < thr_neg) ? 2'd0 : ((dz > thr_pos) ? 2'd2 : 2'd1);
    end

    logic [CODE_W-1:0] s1_code;
    assign s1_code = CODE_W'(bx) + CODE_W'({by, 1'b0}) + CODE_W'(by)
                   + CODE_W'({bz, 3'b000}) + CODE_W'(bz) + CODE_W'(1);

    // per-joint history
    logic [NUM_JOINTS-1:0] seen_reg, seen_next;
    logic [CODE_W-1:0]     last_cube_mem [NUM_JOINTS];
    logic [CODE_W-1:0]     rd_reg;
    logic                  fwd_reg;
    logic [CODE_W-1:0]     fwd_code_reg;
    logic [CODE_W-1:0]     prev_code;
    logic                  seen_eff;
    logic                  s1_emit;
    logic                  wr_en;

    assign prev_code = fwd_reg ? fwd_code_reg : rd_reg;
    assign seen_eff  = !s1_reg.gesture_start && seen_reg[s1_idx];
    assign s1_emit   = s1_in_range && (!seen_eff || prev_code != s1_code);
    assign wr_en     = s1_go && s1_emit;

    always_comb
    begin
        seen_next = s1_reg.gesture_start ? '0 : seen_reg;
        if (s1_emit)
        begin
            seen_next[s1_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            last_cube_mem[s1_idx] <= s1_code;
        end
        if (in_acc)
        begin
            rd_reg       <= last_cube_mem[in_idx];
            fwd_code_reg <= s1_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (s1_go)
            begin
                seen_reg <= seen_next;
            end
            if (in_acc)
            begin
                // bypass a write to the same joint landing at this edge
                fwd_reg <= wr_en && (s1_idx == in_idx);
            end
            if (in_acc)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_vld_reg <= s1_emit;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= in_data;
        end
        if (wr_en)
        begin
            out_reg.out_joint <= s1_reg.joint_index;
            out_reg.cube_code <= s1_code;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    `JCQD_ASSERT(a_code_range,
        out_vld_reg |-> (out_reg.cube_code >= CODE_W'(1) &&
                         out_reg.cube_code <= CODE_W'(27)))
    `JCQD_ASSERT(a_joint_range,
        out_vld_reg |-> ({1'b0, EXT_W'(out_reg.out_joint)} < JOINT_LIMIT))
    `JCQD_ASSERT(a_seen_after_emit, wr_en |=> seen_reg[$past(s1_idx)])
    `JCQD_ASSERT(a_stall_needs_item, in_stall |-> s1_vld_reg)
    `JCQD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_vld_reg && !s1_vld_reg))

endmodule

`default_nettype wire
